>>> design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants and types of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned SYM_W           = 8;
  localparam int unsigned RES_W           = 32;
  localparam int unsigned STAT_W          = 3;

  localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_POW  = 8'h24;
  localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE = 8'h39;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_ILLEGAL = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_POW = 2'd2
  } aluop_t;

  // request to / response from the multicycle ALU
  typedef struct packed {
    logic   start;
    aluop_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic zero_err;
  } alu_rsp_t;

endpackage

>>> design/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/pfe_alu.sv
// ----------------------------------------------------------------------------
// pfe_alu
// Multicycle multiply, signed divide (restoring, one bit per cycle) and
// power (square-and-multiply, a multiply and a square step per exponent bit).
// ----------------------------------------------------------------------------
module pfe_alu
  import pfe_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  alu_req_t               req,
  input  logic [VALUE_WIDTH-1:0] opa,
  input  logic [VALUE_WIDTH-1:0] opb,
  output alu_rsp_t               rsp,
  output logic [VALUE_WIDTH-1:0] res
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(W - 1);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_DIV  = 5'b00100,
    A_PSQ  = 5'b01000,
    A_DONE = 5'b10000
  } astate_t;

  astate_t        state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]   acc_r, acc_nxt;     // quotient / power accumulator
  logic [W-1:0]   rem_r, rem_nxt;     // remainder / power base
  logic [W-1:0]   dvs_r, dvs_nxt;     // divisor magnitude / exponent
  logic           neg_r, neg_nxt;
  logic           zerr_r, zerr_nxt;
  logic           phase_r, phase_nxt; // power: 0 multiply step, 1 square step

  logic [W-1:0]   mag_a, mag_b, mop_a, mop_b, mprod;
  logic [W:0]     trial;
  logic [W-1:0]   rem_sh;

  assign mag_a = opa[W-1] ? (~opa + 1'b1) : opa;
  assign mag_b = opb[W-1] ? (~opb + 1'b1) : opb;

  // single shared multiplier, result registered before reuse
  always_comb begin
    mop_a = acc_r;
    mop_b = rem_r;
    if (state_r == A_PSQ && phase_r) begin
      mop_a = rem_r;
    end
  end
  assign mprod = W'(mop_a * mop_b);

  assign rem_sh = {rem_r[W-2:0], acc_r[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    zerr_nxt  = zerr_r;
    phase_nxt = phase_r;
    case (state_r)
      A_IDLE: begin
        zerr_nxt = 1'b0;
        cnt_nxt  = '0;
        if (req.start) begin
          case (req.op)
            OP_MUL: begin
              acc_nxt   = opa;
              rem_nxt   = opb;
              state_nxt = A_MUL;
            end
            OP_DIV: begin
              acc_nxt   = mag_a;
              rem_nxt   = '0;
              dvs_nxt   = mag_b;
              neg_nxt   = opa[W-1] ^ opb[W-1];
              zerr_nxt  = (opb == '0);
              state_nxt = (opb == '0) ? A_DONE : A_DIV;
            end
            OP_POW: begin
              state_nxt = A_DONE;
              if (opb[W-1]) begin
                if (opa == W'(1)) begin
                  acc_nxt = W'(1);
                end else if (opa == '1) begin
                  acc_nxt = opb[0] ? '1 : W'(1);
                end else if (opa == '0) begin
                  zerr_nxt = 1'b1;
                end else begin
                  acc_nxt = '0;
                end
              end else begin
                acc_nxt   = W'(1);
                rem_nxt   = opa;
                dvs_nxt   = opb;
                phase_nxt = 1'b0;
                state_nxt = A_PSQ;
              end
            end
            default: state_nxt = A_DONE;
          endcase
        end
      end
      A_MUL: begin
        acc_nxt   = mprod;
        state_nxt = A_DONE;
      end
      A_DIV: begin
        if (!trial[W]) begin
          rem_nxt = trial[W-1:0];
          acc_nxt = {acc_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          acc_nxt = {acc_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          state_nxt = A_DONE;
          if (neg_r) begin
            acc_nxt = ~acc_nxt + 1'b1;
          end
        end
      end
      A_PSQ: begin
        if (!phase_r) begin
          if (dvs_r[0]) begin
            acc_nxt = mprod;
          end
          phase_nxt = 1'b1;
        end else begin
          rem_nxt   = mprod;
          dvs_nxt   = {1'b0, dvs_r[W-1:1]};
          phase_nxt = 1'b0;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == LAST_CNT || dvs_r[W-1:1] == '0) begin
            state_nxt = A_DONE;
          end
        end
      end
      A_DONE:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    zerr_r  <= zerr_nxt;
    phase_r <= phase_nxt;
  end

  assign rsp.done     = (state_r == A_DONE);
  assign rsp.zero_err = zerr_r;
  assign res          = acc_r;

endmodule

>>> design/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix (RPN) evaluator over a RAM-held operand stack.
// ----------------------------------------------------------------------------
// Usage: one character word per input handshake (in_valid/in_stall) with
// in_last marking the end of the expression. Digits push, + - * / $ pop two
// operands and push the result. One output word (out_result, out_status)
// is produced only for a word with in_last set; out_valid holds until
// out_stall is low, and the output register lets the next input be taken
// meanwhile, except a last word, which waits for the held result to leave.
// Sequence, one word at a time: a digit push or skipped word is taken in
//   S_IDLE; an operator reads both operands (S_RDB, S_RDA), then adds or
//   subtracts in S_EXEC or runs the ALU (S_ALU), and writes back in S_WR.
//   A last word then reads the top of stack (S_TOP) and emits (S_EMIT).
// Reset empties the stack and clears the error; RAM contents need no
// clearing. An error latches until the last word of the expression.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
  import pfe_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SYM_W-1:0]        in_symbol,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_result,
  output logic [STAT_W-1:0]       out_status
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RDB   = 8'b00000010,
    S_RDA   = 8'b00000100,
    S_EXEC  = 8'b00001000,
    S_ALU   = 8'b00010000,
    S_WR    = 8'b00100000,
    S_TOP   = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [PW-1:0]    sp_r, sp_nxt;
  status_t          err_r, err_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             last_r, last_nxt;
  logic [W-1:0]     opb_r, opb_nxt;
  logic [W-1:0]     wval_r, wval_nxt;
  logic             ovld_r, ovld_nxt;
  logic [RES_W-1:0] ores_r, ores_nxt;
  status_t          osts_r, osts_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [W-1:0]     ram_wdata, ram_rdata;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [W-1:0]     alu_res;
  logic             is_digit, is_op;

  pfe_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pfe_alu #(.VALUE_WIDTH(W)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (ram_rdata),
    .opb   (opb_r),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  assign is_digit = (in_symbol >= CH_ZERO) && (in_symbol <= CH_NINE);
  assign is_op    = (in_symbol == CH_ADD) || (in_symbol == CH_SUB) ||
                    (in_symbol == CH_MUL) || (in_symbol == CH_DIV) ||
                    (in_symbol == CH_POW);

  // a last word may not be taken while the previous result is still held
  assign in_stall = (state_r != S_IDLE) || (ovld_r && in_last);

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    err_nxt   = err_r;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    opb_nxt   = opb_r;
    wval_nxt  = wval_r;
    ovld_nxt  = ovld_r && out_stall;
    ores_nxt  = ores_r;
    osts_nxt  = osts_r;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = wval_r;
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          sym_nxt   = in_symbol;
          last_nxt  = in_last;
          state_nxt = in_last ? S_TOP : S_IDLE;
          if (err_r == ST_OK) begin
            if (is_digit) begin
              if (sp_r >= FULL) begin
                err_nxt = ST_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = sp_r[AW-1:0];
                ram_wdata = W'(in_symbol - CH_ZERO);
                sp_nxt    = sp_r + 1'b1;
              end
            end else if (!is_op) begin
              err_nxt = ST_ILLEGAL;
            end else if (sp_r < PW'(2)) begin
              err_nxt = ST_UNDER;
            end else begin
              ram_addr  = AW'(sp_r - PW'(1));
              state_nxt = S_RDB;
            end
          end
        end
      end
      S_RDB: begin
        opb_nxt   = ram_rdata;
        ram_addr  = AW'(sp_r - PW'(2));
        state_nxt = S_RDA;
      end
      S_RDA: begin
        ram_addr  = AW'(sp_r - PW'(2));
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // left operand is on ram_rdata now
        if (sym_r == CH_ADD) begin
          wval_nxt  = ram_rdata + opb_r;
          state_nxt = S_WR;
        end else if (sym_r == CH_SUB) begin
          wval_nxt  = ram_rdata - opb_r;
          state_nxt = S_WR;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = (sym_r == CH_MUL) ? OP_MUL :
                          (sym_r == CH_DIV) ? OP_DIV : OP_POW;
          state_nxt     = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          if (alu_rsp.zero_err) begin
            err_nxt   = ST_DIVZERO;
            state_nxt = last_r ? S_TOP : S_IDLE;
          end else begin
            wval_nxt  = alu_res;
            state_nxt = S_WR;
          end
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(sp_r - PW'(2));
        sp_nxt    = sp_r - 1'b1;
        state_nxt = last_r ? S_TOP : S_IDLE;
      end
      S_TOP: begin
        ram_addr  = AW'(sp_r - PW'(1));
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        ovld_nxt = 1'b1;
        ores_nxt = '0;
        if (err_r == ST_OK && sp_r == '0) begin
          osts_nxt = ST_UNDER;
        end else begin
          osts_nxt = err_r;
          if (err_r == ST_OK) begin
            ores_nxt = RES_W'($signed(ram_rdata));
          end
        end
        sp_nxt    = '0;
        err_nxt   = ST_OK;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      err_r   <= ST_OK;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
      ovld_r  <= ovld_nxt;
    end
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    opb_r  <= opb_nxt;
    wval_r <= wval_nxt;
    ores_r <= ores_nxt;
    osts_r <= osts_nxt;
  end

  assign out_valid  = ovld_r;
  assign out_result = ores_r;
  assign out_status = osts_r;

  // stack pointer never passes the depth
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= FULL) else $error("stack pointer beyond depth");

  // a reported error carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_result == '0))
    else $error("nonzero result with error");

  // emitting a result empties the stack
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> (sp_r == '0 && err_r == ST_OK))
    else $error("stack not cleared after result");

endmodule
